// ----- rtl/lpf_pkg.sv -----
// Shared types, constants and helpers for the logarithmic potential force pipeline.
`default_nettype none
package lpf_pkg;

	localparam int RAD_W      = 57;
	localparam int NUM_W      = 89;
	localparam int QUO_W      = 48;
	localparam int FRAC_STEPS = 28;
	localparam int FRONT_LAT  = 5;
	localparam int LOG_LAT    = 2 + FRAC_STEPS + 4;
	localparam int DIV_LAT    = QUO_W + 2;
	localparam int PIPE_DEPTH = FRONT_LAT + DIV_LAT;
	localparam int LOG_END    = FRONT_LAT + LOG_LAT;

	localparam logic [23:0] WEIGHT_X = 24'h01_0000;
	localparam logic [27:0] LN2_Q28  = 28'd186065279;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_ZERO = 2'd1;
	localparam logic [1:0] STATUS_SAT  = 2'd2;

	typedef enum logic [2:0] {
		REG_CORE_SCALE  = 3'd0,
		REG_CORE_RAD_SQ = 3'd1,
		REG_WEIGHT_Y    = 3'd2,
		REG_WEIGHT_Z    = 3'd3,
		REG_DIMS        = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] potential;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		logic signed [31:0] acc_z;
		logic [1:0]         status;
	} out_word_t;

	typedef struct packed {
		logic [31:0] core_scale;
		logic [31:0] core_radius_sq;
		logic [23:0] weight_y;
		logic [23:0] weight_z;
		logic [1:0]  dims_in_use;
	} cfg_t;

	// Apply sign to a magnitude and clamp to signed 32 bit; returns {sat, value}.
	function automatic logic [32:0] sat_word(input logic [39:0] mag, input logic neg,
		input logic huge);
		logic [32:0] r;
		if (neg) begin
			if (huge || (mag > 40'h00_8000_0000)) r = {1'b1, 32'h8000_0000};
			else r = {1'b0, 32'(40'd0 - mag)};
		end else begin
			if (huge || (mag > 40'h00_7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
			else r = {1'b0, mag[31:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/lpf_front.sv -----
// Front stages: coordinate magnitudes, weighted squares, radius sum and divider numerators.
`default_nettype none
module lpf_front (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire lpf_pkg::in_word_t              in_word,
	input  wire lpf_pkg::cfg_t                  cfg,
	output logic [lpf_pkg::RAD_W-1:0]           rad,
	output logic [2:0][lpf_pkg::NUM_W-1:0]      num,
	output logic [2:0]                          pneg
);
	logic [2:0][31:0] pos_c;
	logic [2:0][31:0] mag_c;
	logic [2:0][23:0] w_c;

	logic [2:0][31:0] mag_s1;
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [2:0][63:0] sq_s2, a_s2;
	logic [2:0][55:0] wl_s3, wh_s3;
	logic [2:0][56:0] nl_s3, nh_s3;
	logic [2:0][lpf_pkg::RAD_W-1:0] term_s4;
	logic [2:0][lpf_pkg::NUM_W-1:0] num_s4, num_s5;
	logic [lpf_pkg::RAD_W-1:0]      rad_s5;

	assign pos_c = {in_word.pos_z, in_word.pos_y, in_word.pos_x};
	assign w_c   = {cfg.weight_z, cfg.weight_y, lpf_pkg::WEIGHT_X};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = pos_c[i][31] ? 32'(32'd0 - pos_c[i]) : pos_c[i];
			// drop coordinates past the active count
			if (i >= int'(cfg.dims_in_use)) mag_c[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i]  <= mag_c[i];
				neg_s1[i]  <= pos_c[i][31];
				sq_s2[i]   <= mag_s1[i] * mag_s1[i];
				a_s2[i]    <= cfg.core_scale * mag_s1[i];
				wl_s3[i]   <= sq_s2[i][31:0] * w_c[i];
				wh_s3[i]   <= sq_s2[i][63:32] * w_c[i];
				nl_s3[i]   <= a_s2[i][31:0] * {w_c[i], 1'b0};
				nh_s3[i]   <= a_s2[i][63:32] * {w_c[i], 1'b0};
				term_s4[i] <= lpf_pkg::RAD_W'(wh_s3[i]) + lpf_pkg::RAD_W'(wl_s3[i][55:32]);
				num_s4[i]  <= {nh_s3[i], 32'd0} + lpf_pkg::NUM_W'(nl_s3[i]);
				num_s5[i]  <= num_s4[i];
			end
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			neg_s4 <= neg_s3;
			neg_s5 <= neg_s4;
			rad_s5 <= lpf_pkg::RAD_W'(cfg.core_radius_sq) + term_s4[0] + term_s4[1]
				+ term_s4[2];
		end
	end

	assign rad  = rad_s5;
	assign num  = num_s5;
	assign pneg = neg_s5;
endmodule
`default_nettype wire

// ----- rtl/lpf_log.sv -----
// Natural log of the radius by repeated squaring, scaled by core_scale into the potential.
`default_nettype none
module lpf_log (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [lpf_pkg::RAD_W-1:0] rad,
	input  wire logic [31:0]               core_scale,
	output logic [31:0]                    pot,
	output logic                           psat
);
	localparam int LAST = 2 + lpf_pkg::FRAC_STEPS;

	logic [5:0]                e_c;
	logic [30:0]               m_c;
	logic [5:0]                e_s1;
	logic [lpf_pkg::RAD_W-1:0] rad_s1;
	logic [30:0]               m_s    [2:LAST];
	logic [27:0]               frac_s [2:LAST];
	logic [5:0]                e_s    [2:LAST];

	logic signed [6:0]  ev_c;
	logic signed [35:0] l_c;
	logic [34:0]        lmag_s31;
	logic               lneg_s31, lneg_s32, lneg_s33;
	logic [62:0]        prod_c;
	logic [63:0]        rnd_c;
	logic [30:0]        lnmag_s32;
	logic [62:0]        pprod_s33;
	logic [63:0]        prnd_c;
	logic [32:0]        sw_c;
	logic [31:0]        pot_s34;
	logic               psat_s34;

	// leading one of the radius
	always_comb begin
		e_c = '0;
		for (int i = 0; i < lpf_pkg::RAD_W; i++) begin
			if (rad[i]) e_c = 6'(i);
		end
	end

	// normalize to Q1.30
	always_comb begin
		if (e_s1 <= 6'd30) m_c = rad_s1[30:0] << (6'd30 - e_s1);
		else m_c = 31'(rad_s1 >> (e_s1 - 6'd30));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1      <= e_c;
			rad_s1    <= rad;
			m_s[2]    <= m_c;
			e_s[2]    <= e_s1;
			frac_s[2] <= '0;
		end
	end

	// one fraction bit per squaring stage
	for (genvar k = 3; k <= LAST; k++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] t;
		assign sq = m_s[k-1] * m_s[k-1];
		assign t  = sq[61:30];
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[k]    <= t[31] ? t[31:1] : t[30:0];
				frac_s[k] <= {frac_s[k-1][26:0], t[31]};
				e_s[k]    <= e_s[k-1];
			end
		end
	end

	always_comb begin
		ev_c   = $signed({1'b0, e_s[LAST]}) - 7'sd16;
		l_c    = (36'(ev_c) <<< 28) + $signed({8'd0, frac_s[LAST]});
		prod_c = lmag_s31 * lpf_pkg::LN2_Q28;
		rnd_c  = {1'b0, prod_c} + 64'h8000_0000;
		prnd_c = {1'b0, pprod_s33} + 64'h80_0000;
		sw_c   = lpf_pkg::sat_word(prnd_c[63:24], lneg_s33, 1'b0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lneg_s31  <= l_c[35];
			lmag_s31  <= l_c[35] ? 35'(36'sd0 - l_c) : 35'(l_c);
			lnmag_s32 <= rnd_c[62:32];
			lneg_s32  <= lneg_s31;
			pprod_s33 <= lnmag_s32 * core_scale;
			lneg_s33  <= lneg_s32;
			pot_s34   <= sw_c[31:0];
			psat_s34  <= sw_c[32];
		end
	end

	assign pot  = pot_s34;
	assign psat = psat_s34;
endmodule
`default_nettype wire

// ----- rtl/lpf_div.sv -----
// Three-lane restoring divider, one quotient bit per stage, with rounding and clamping.
`default_nettype none
module lpf_div (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [2:0][lpf_pkg::NUM_W-1:0]    num,
	input  wire logic [lpf_pkg::RAD_W-1:0]         rad,
	input  wire logic [2:0]                        pneg,
	output logic [2:0][31:0]                       acc,
	output logic [2:0]                             sat
);
	localparam int RW   = lpf_pkg::RAD_W;
	localparam int QW   = lpf_pkg::QUO_W;
	localparam int LAST = QW + 1;

	logic [RW-1:0]       rad_s  [1:LAST];
	logic [2:0][RW-1:0]  rem_s  [1:LAST];
	logic [2:0][QW-1:0]  lo_s   [1:LAST];
	logic [2:0]          huge_s [1:LAST];
	logic [2:0]          neg_s  [1:LAST];
	logic [2:0][31:0]    acc_s50;
	logic [2:0]          sat_s50;
	logic [2:0][48:0]    r_c;
	logic [2:0][32:0]    sw_c;

	// quotient above 48 bits means the upper dividend part already covers rad
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[1] <= rad;
			neg_s[1] <= pneg;
			for (int i = 0; i < 3; i++) begin
				huge_s[1][i] <= RW'(num[i][lpf_pkg::NUM_W-1:QW]) >= rad;
				rem_s[1][i]  <= RW'(num[i][lpf_pkg::NUM_W-1:QW]);
				lo_s[1][i]   <= num[i][QW-1:0];
			end
		end
	end

	// dividend bits shift out of lo while quotient bits shift in
	for (genvar k = 2; k <= LAST; k++) begin : g_step
		logic [2:0][RW:0] rem2;
		logic [2:0]       ge;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rem2[i] = {rem_s[k-1][i], lo_s[k-1][i][QW-1]};
				ge[i]   = rem2[i] >= {1'b0, rad_s[k-1]};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				huge_s[k] <= huge_s[k-1];
				for (int i = 0; i < 3; i++) begin
					rem_s[k][i] <= ge[i] ? RW'(rem2[i] - {1'b0, rad_s[k-1]}) : rem2[i][RW-1:0];
					lo_s[k][i]  <= {lo_s[k-1][i][QW-2:0], ge[i]};
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_c[i]  = {1'b0, lo_s[LAST][i]} + 49'h8000;
			sw_c[i] = lpf_pkg::sat_word({7'd0, r_c[i][48:16]}, !neg_s[LAST][i],
				huge_s[LAST][i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				acc_s50[i] <= sw_c[i][31:0];
				sat_s50[i] <= sw_c[i][32];
			end
		end
	end

	assign acc = acc_s50;
	assign sat = sat_s50;
endmodule
`default_nettype wire

// ----- rtl/log_potential_force_top.sv -----
// Top level: configuration registers, pipeline control, path alignment and result register.
// Throughput: one word per cycle while the pipeline is not held; the 48-stage quotient chain sets the depth.
// The pipeline holds only when a result in its last stage meets a held output word.
// Reset clears all valid bits and loads the register reset values.
`default_nettype none
module log_potential_force_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire lpf_pkg::in_word_t   in_word,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output lpf_pkg::out_word_t       out_word,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);
	localparam int FL = lpf_pkg::FRONT_LAT;
	localparam int LE = lpf_pkg::LOG_END;
	localparam int PD = lpf_pkg::PIPE_DEPTH;

	lpf_pkg::cfg_t cfg_q;
	logic          en;
	logic          vld_s [1:PD];

	logic [lpf_pkg::RAD_W-1:0]      rad;
	logic [2:0][lpf_pkg::NUM_W-1:0] num;
	logic [2:0]                     pneg;
	logic [31:0]                    pot;
	logic                           psat;
	logic [2:0][31:0]               acc;
	logic [2:0]                     sat;

	logic        zero_s [FL+1:PD];
	logic [31:0] pot_s  [LE+1:PD];
	logic        psat_s [LE+1:PD];

	lpf_pkg::out_word_t res_c;
	lpf_pkg::out_word_t out_word_q;
	logic               out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.core_scale     <= 32'h0001_0000;
			cfg_q.core_radius_sq <= 32'h0001_0000;
			cfg_q.weight_y       <= 24'h01_0000;
			cfg_q.weight_z       <= 24'h01_0000;
			cfg_q.dims_in_use    <= 2'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lpf_pkg::REG_CORE_SCALE:  cfg_q.core_scale     <= cfg_data;
				lpf_pkg::REG_CORE_RAD_SQ: cfg_q.core_radius_sq <= cfg_data;
				lpf_pkg::REG_WEIGHT_Y:    cfg_q.weight_y       <= cfg_data[23:0];
				lpf_pkg::REG_WEIGHT_Z:    cfg_q.weight_z       <= cfg_data[23:0];
				lpf_pkg::REG_DIMS:        cfg_q.dims_in_use    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// hold the pipe only when its last word cannot move into the output register
	assign en       = !(vld_s[PD] && out_valid_q && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= PD; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= PD; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	lpf_front u_front (
		.clk     (clk),
		.en      (en),
		.in_word (in_word),
		.cfg     (cfg_q),
		.rad     (rad),
		.num     (num),
		.pneg    (pneg)
	);

	lpf_log u_log (
		.clk        (clk),
		.en         (en),
		.rad        (rad),
		.core_scale (cfg_q.core_scale),
		.pot        (pot),
		.psat       (psat)
	);

	lpf_div u_div (
		.clk  (clk),
		.en   (en),
		.num  (num),
		.rad  (rad),
		.pneg (pneg),
		.acc  (acc),
		.sat  (sat)
	);

	// align the zero flag and the potential with the divider output
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[FL+1] <= (rad == '0);
			for (int k = FL + 2; k <= PD; k++) zero_s[k] <= zero_s[k-1];
			pot_s[LE+1]  <= pot;
			psat_s[LE+1] <= psat;
			for (int k = LE + 2; k <= PD; k++) begin
				pot_s[k]  <= pot_s[k-1];
				psat_s[k] <= psat_s[k-1];
			end
		end
	end

	always_comb begin
		if (zero_s[PD]) begin
			res_c        = '0;
			res_c.status = lpf_pkg::STATUS_ZERO;
		end else begin
			res_c.potential = pot_s[PD];
			res_c.acc_x     = acc[0];
			res_c.acc_y     = acc[1];
			res_c.acc_z     = acc[2];
			res_c.status    = (psat_s[PD] || (sat != 3'd0)) ? lpf_pkg::STATUS_SAT
				: lpf_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (vld_s[PD] && en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s[PD] && en) out_word_q <= res_c;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && vld_s[PD]))
		else $error("input held without a blocked result");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_word.status == lpf_pkg::STATUS_ZERO)) |->
		((out_word.potential == 32'sd0) && (out_word.acc_x == 32'sd0)
		&& (out_word.acc_y == 32'sd0) && (out_word.acc_z == 32'sd0)))
		else $error("zero radius result carries nonzero fields");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_word.status == lpf_pkg::STATUS_OK)
		|| (out_word.status == lpf_pkg::STATUS_ZERO)
		|| (out_word.status == lpf_pkg::STATUS_SAT)))
		else $error("undefined status code");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[PD] && out_valid && out_stall) |=> vld_s[PD])
		else $error("last stage word lost while output held");
endmodule
`default_nettype wire

// ----- test/lpf_checker.sv -----
// Checker for the logarithmic potential force block: predicts each result word and compares.
`timescale 1ns / 100ps
module lpf_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire lpf_pkg::in_word_t  in_word,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire lpf_pkg::out_word_t out_word,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	output int                      fails,
	output int                      pending
);
	import lpf_pkg::*;

	cfg_t      regs;
	out_word_t force_q[$];

	// Clamp a magnitude with sign to signed 32 bit; returns {saturated, value}.
	function automatic logic [32:0] clamp_q16(input logic [63:0] mag, input logic neg,
		input logic huge);
		if (neg)
			return (huge || mag > 64'h8000_0000) ? {1'b1, 32'h8000_0000}
				: {1'b0, 32'(64'd0 - mag)};
		return (huge || mag > 64'h7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, mag[31:0]};
	endfunction

	function automatic out_word_t predict_force(input in_word_t p);
		logic [31:0]        raw [3];
		logic [63:0]        mag [3];
		logic [63:0]        w [3];
		logic               neg [3];
		logic [31:0]        acc [3];
		logic [63:0]        rad, sq, m, frac, lmag, lnmag, pmag, q16;
		logic signed [63:0] l;
		logic [127:0]       num, quo;
		logic [32:0]        cv;
		logic               sat, lneg, huge;
		int                 e;
		out_word_t          r;
		raw[0] = p.pos_x;
		raw[1] = p.pos_y;
		raw[2] = p.pos_z;
		w[0] = 64'(WEIGHT_X);
		w[1] = 64'(regs.weight_y);
		w[2] = 64'(regs.weight_z);
		rad = 64'(regs.core_radius_sq);
		sat = 1'b0;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = raw[i][31];
			mag[i] = neg[i] ? (64'h1_0000_0000 - {32'd0, raw[i]}) : {32'd0, raw[i]};
			if (i >= int'(regs.dims_in_use)) mag[i] = 0;
			sq = mag[i] * mag[i];
			rad += (sq >> 32) * w[i] + (((sq & 64'hFFFF_FFFF) * w[i]) >> 32);
		end
		if (rad == 0) begin
			r.status = STATUS_ZERO;
			return r;
		end
		e = 0;
		for (int k = 63; k >= 0; k--)
			if (rad[k]) begin
				e = k;
				break;
			end
		m = (e <= 30) ? (rad << (30 - e)) : (rad >> (e - 30));
		frac = 0;
		for (int i = 0; i < FRAC_STEPS; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		l = (64'(e) - 64'sd16) * (64'sd1 <<< 28) + $signed(frac);
		lneg = l < 0;
		lmag = lneg ? 64'(-l) : 64'(l);
		lnmag = (lmag * 64'(LN2_Q28) + (64'd1 << 31)) >> 32;
		pmag = (lnmag * 64'(regs.core_scale) + (64'd1 << 23)) >> 24;
		cv = clamp_q16(pmag, lneg, 1'b0);
		sat |= cv[32];
		r.potential = cv[31:0];
		for (int i = 0; i < 3; i++) begin
			acc[i] = 0;
			if (mag[i] != 0) begin
				num = 128'(64'(regs.core_scale) * mag[i]) * 128'(2 * w[i]);
				quo = num / 128'(rad);
				huge = quo >= (128'd1 << 48);
				q16 = huge ? 64'd0 : ((quo[63:0] + 64'h8000) >> 16);
				cv = clamp_q16(q16, !neg[i], huge);
				sat |= cv[32];
				acc[i] = cv[31:0];
			end
		end
		r.acc_x = acc[0];
		r.acc_y = acc[1];
		r.acc_z = acc[2];
		r.status = sat ? STATUS_SAT : STATUS_OK;
		return r;
	endfunction

	assign pending = force_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs <= '{core_scale: 32'h1_0000, core_radius_sq: 32'h1_0000,
				weight_y: 24'h1_0000, weight_z: 24'h1_0000, dims_in_use: 2'd3};
			fails <= 0;
			force_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_CORE_SCALE:  regs.core_scale <= cfg_data;
				REG_CORE_RAD_SQ: regs.core_radius_sq <= cfg_data;
				REG_WEIGHT_Y:    regs.weight_y <= cfg_data[23:0];
				REG_WEIGHT_Z:    regs.weight_z <= cfg_data[23:0];
				REG_DIMS:        regs.dims_in_use <= cfg_data[1:0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				force_q.push_back(predict_force(in_word));
			if (out_valid && !out_stall) begin
				if (force_q.size() == 0) begin
					if (fails < 10) $display("unexpected result word %h", out_word);
					fails <= fails + 1;
				end else if (force_q[0] !== out_word) begin
					if (fails < 10)
						$display("word mismatch: pot %h/%h ax %h/%h ay %h/%h az %h/%h st %0d/%0d",
							force_q[0].potential, out_word.potential,
							force_q[0].acc_x, out_word.acc_x,
							force_q[0].acc_y, out_word.acc_y,
							force_q[0].acc_z, out_word.acc_z,
							force_q[0].status, out_word.status);
					fails <= fails + 1;
					void'(force_q.pop_front());
				end else begin
					void'(force_q.pop_front());
				end
			end
		end
	end
endmodule

// ----- test/tb.sv -----
// Testbench top: drives positions and register writes into the force block and gives the verdict.
`timescale 1ns / 100ps
module tb;
	import lpf_pkg::*;

	localparam logic [2:0] REG_LAST = REG_DIMS;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	in_word_t           in_word = '0;
	logic               out_valid;
	logic               out_stall = 0;
	out_word_t          out_word;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	int                 fails, pending;
	bit                 hold_req = 0, hold_done = 0;

	log_potential_force_top dut (.*);

	lpf_checker chk (.*);

	initial forever #5 clk = ~clk;

	initial begin
		#20ms;
		$display("log_potential_force_top: mismatch");
		$finish;
	end

	// Receiver: stall pattern switches among three modes at random; one long hold on request.
	initial begin
		int mode, left;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_done = 1;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(50, 400);
			end
			left--;
			case (mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic send_pos(input in_word_t p);
		logic stalled;
		in_valid <= 1'b1;
		in_word <= p;
		forever begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
			if (!stalled) break;
		end
	endtask

	task automatic idle(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		forever begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
			if (rdy) break;
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_val(input logic [31:0] maxv);
		case ($urandom_range(0, 5))
		0: return 0;
		1: return maxv;
		2: return 32'h1_0000;
		3: return $urandom_range(0, 32'h4_0000) & maxv;
		default: return $urandom & maxv;
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 7))
		0: return 0;
		1: return 32'h8000_0000;
		2: return 32'h7FFF_FFFF;
		3: return 32'($signed($urandom_range(0, 64)) - 32);
		4, 5: return 32'($signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000);
		default: return $urandom;
		endcase
	endfunction

	task automatic run_random(input int n, input bit pause_mid, input bit long_hold);
		int left;
		left = 0;
		for (int i = 0; i < n; i++) begin
			if (left == 0) begin
				left = $urandom_range(1, 30);
				if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 6));
			end
			left--;
			if (long_hold && i == n / 4) hold_req = 1;
			if (pause_mid && i == n / 2) drain();
			send_pos('{pos_x: rand_coord(), pos_y: rand_coord(), pos_z: rand_coord()});
		end
	endtask

	initial begin
		in_word_t dir [$];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		dir = '{'{0, 0, 0}, '{32'h1_0000, 0, 0}, '{32'hFFFF_0000, 32'h1_0000, 32'h1_0000},
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			'{32'hFFFF_FFFF, 1, 32'hFFFF_FFFF}, '{1, 0, 32'h8000_0000},
			'{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F}};
		foreach (dir[i]) send_pos(dir[i]);
		drain();
		// zero radius, dims zero, and a write to an undefined register index
		write_reg(REG_CORE_RAD_SQ, 0);
		write_reg(REG_DIMS, 0);
		write_reg(REG_LAST + 3'd1, 32'hFFFF_FFFF);
		foreach (dir[i]) send_pos(dir[i]);
		drain();
		write_reg(REG_DIMS, 1);
		write_reg(REG_CORE_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_WEIGHT_Y, 24'hFF_FFFF);
		write_reg(REG_WEIGHT_Z, 0);
		send_pos('{0, 32'h1_0000, 0});
		send_pos('{1, 0, 0});
		send_pos('{32'hFFFF_FFFF, 0, 0});
		drain();
		write_reg(REG_DIMS, 3);
		foreach (dir[i]) send_pos(dir[i]);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_CORE_SCALE, pick_val(32'hFFFF_FFFF));
			write_reg(REG_CORE_RAD_SQ, pick_val(32'hFFFF_FFFF));
			write_reg(REG_WEIGHT_Y, $urandom);
			write_reg(REG_WEIGHT_Z, pick_val(32'hFF_FFFF));
			write_reg(REG_DIMS, (ph < 4) ? 32'd3 : $urandom);
			if (ph == 7) write_reg(REG_LAST + 3'($urandom_range(1, 3)), $urandom);
			run_random(150, ph == 2, ph == 1);
			drain();
		end

		if (fails == 0) begin
			$display("log_potential_force_top: match");
		end else begin
			$display("log_potential_force_top: mismatch");
		end
		$finish;
	end
endmodule
